FILE: rtl/fdbp_pkg.sv
// Shared types and constants of the fit-decreasing bin packer.
`default_nettype none
package fdbp_pkg;

  localparam int unsigned MaxRequestsDef = 32;
  localparam int unsigned MaxBinsDef     = 16;
  localparam int unsigned BinW           = 4;
  localparam int unsigned CostW          = 21;

  localparam logic [1:0] OpVehicle = 2'd0;
  localparam logic [1:0] OpRequest = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        vehicle_capacity;
    logic [9:0]         req_id;
    logic signed [15:0] demand;
    logic [15:0]        trip_distance;
    logic               last;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [9:0]       out_request_id;
    logic [BinW-1:0]  bin_index;
    logic             assigned;
    logic [15:0]      bin_load;
    logic [CostW-1:0] bin_cost;
    logic             overflow;
    logic             last_out;
  } result_t;

  typedef struct packed {
    logic [14:0] size;
    logic [15:0] trip;
    logic [9:0]  id;
  } req_entry_t;

  typedef struct packed {
    logic             fits;
    logic [15:0]      left;
    logic [15:0]      new_load;
    logic [CostW-1:0] new_cost;
  } fit_res_t;

endpackage
`default_nettype wire

FILE: rtl/fit_decreasing_bin_packer.sv
// Top level of the fit-decreasing bin packer: sequencer, request memory and bin tables.
//
// Items are offered on item_i with start; one is taken when start is high and busy
// is low. Op 0 appends a vehicle capacity, op 2 clears the vehicle table and op 3
// does nothing. Op 1 stores a request by insertion into a memory kept sorted by
// decreasing size (equal sizes in arrival order); each entry moved takes an INS_RD
// read and an INS_CMP write. A request with last set starts packing: for each sorted
// request the open bins are scanned one per cycle through the shared fit unit (best
// fit always scans every open bin, first fit stops at the first bin that fits), and
// its record is registered onto result_o in PK_PLACE. Then one bin record per cycle
// follows. busy stays high for the whole run. Each record is shown for one cycle with
// result_valid_o; the receiver cannot stall. The APB port holds fit_mode at
// address 0. Reset empties the vehicle table and the batch and clears fit_mode.
`default_nettype none
module fit_decreasing_bin_packer #(
  parameter int unsigned MAX_REQUESTS = fdbp_pkg::MaxRequestsDef,
  parameter int unsigned MAX_BINS     = fdbp_pkg::MaxBinsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire fdbp_pkg::item_t   item_i,
  output      logic              result_valid_o,
  output      fdbp_pkg::result_t result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);
  localparam int unsigned RiW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned RcW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned BiW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned BcW = $clog2(MAX_BINS + 1);

  typedef enum logic [6:0] {
    IDLE     = 7'b0000001,
    INS_RD   = 7'b0000010,
    INS_CMP  = 7'b0000100,
    PK_RD    = 7'b0001000,
    PK_SCAN  = 7'b0010000,
    PK_PLACE = 7'b0100000,
    BIN_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic fit_mode_q;
  logic [BcW-1:0] vcount_q, open_q, b_q;
  logic [RcW-1:0] rcount_q, j_q, i_q;
  logic overflow_q, last_q, found_q, opening_q;
  logic [BiW-1:0] best_q;
  logic [15:0] best_left_q;
  fdbp_pkg::req_entry_t new_q;

  logic [15:0] caps_q [MAX_BINS];
  logic [15:0] load_q [MAX_BINS];
  logic [fdbp_pkg::CostW-1:0] cost_q [MAX_BINS];

  fdbp_pkg::req_entry_t req_mem [MAX_REQUESTS];
  fdbp_pkg::req_entry_t rdata_q;
  logic mem_we, mem_re;
  logic [RiW-1:0] mem_waddr, mem_raddr;
  fdbp_pkg::req_entry_t mem_wdata;

  logic accept;
  logic [15:0] dem_u, mag;
  fdbp_pkg::req_entry_t in_entry;
  logic [RcW-1:0] jm1;
  logic [BiW-1:0] rd_idx;
  logic [15:0] u_load;
  logic [fdbp_pkg::CostW-1:0] u_cost;
  fdbp_pkg::fit_res_t fit;
  logic better;

  assign accept = start && !busy;
  assign busy   = state_q != IDLE;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, fit_mode_q};

  always_comb begin
    dem_u = item_i.demand;
    mag   = dem_u[15] ? (~dem_u + 16'd1) : dem_u;
    in_entry.size = mag[15] ? 15'h7FFF : mag[14:0];
    in_entry.trip = item_i.trip_distance;
    in_entry.id   = item_i.req_id;
  end

  assign jm1    = j_q - RcW'(1);
  assign rd_idx = (state_q == PK_PLACE) ? best_q : b_q[BiW-1:0];
  assign u_load = (state_q == PK_PLACE && opening_q) ? 16'd0 : load_q[rd_idx];
  assign u_cost = (state_q == PK_PLACE && opening_q) ? '0 : cost_q[rd_idx];

  fdbp_fit_unit u_fit (
    .load_i (u_load),
    .size_i (rdata_q.size),
    .cap_i  (caps_q[rd_idx]),
    .cost_i (u_cost),
    .dist_i (rdata_q.trip),
    .res_o  (fit)
  );

  assign better = fit.fits && (!found_q || (fit_mode_q && fit.left < best_left_q));

  // Memory port control for the insertion sort and the packing reads.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = j_q[RiW-1:0];
    mem_raddr = jm1[RiW-1:0];
    mem_wdata = new_q;
    case (state_q)
      INS_RD: begin
        if (j_q == '0) mem_we = 1'b1;
        else mem_re = 1'b1;
      end
      INS_CMP: begin
        mem_we = 1'b1;
        if (rdata_q.size < new_q.size) mem_wdata = rdata_q;
      end
      PK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = i_q[RiW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) req_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= req_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.op == fdbp_pkg::OpVehicle && vcount_q < BcW'(MAX_BINS)) begin
      caps_q[vcount_q[BiW-1:0]] <= item_i.vehicle_capacity;
    end
    if (state_q == PK_PLACE && found_q) begin
      load_q[best_q] <= fit.new_load;
      cost_q[best_q] <= fit.new_cost;
    end
    if (accept && item_i.op == fdbp_pkg::OpRequest) new_q <= in_entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      fit_mode_q <= pwdata[0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      IDLE:    if (accept && item_i.op == fdbp_pkg::OpRequest) begin
        if (rcount_q < RcW'(MAX_REQUESTS)) state_d = INS_RD;
        else if (item_i.last) state_d = PK_RD;
      end
      INS_RD:  if (j_q == '0) state_d = last_q ? PK_RD : IDLE;
               else state_d = INS_CMP;
      INS_CMP: if (rdata_q.size < new_q.size) state_d = INS_RD;
               else state_d = last_q ? PK_RD : IDLE;
      PK_RD:   state_d = PK_SCAN;
      PK_SCAN: if (b_q < open_q) begin
        if (!fit_mode_q && fit.fits) state_d = PK_PLACE;
      end else begin
        state_d = PK_PLACE;
      end
      PK_PLACE: if (i_q + RcW'(1) == rcount_q) state_d = (open_q == '0) ? IDLE : BIN_EMIT;
                else state_d = PK_RD;
      BIN_EMIT: if (b_q + BcW'(1) == open_q) state_d = IDLE;
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= IDLE;
      vcount_q       <= '0;
      rcount_q       <= '0;
      open_q         <= '0;
      overflow_q     <= 1'b0;
      last_q         <= 1'b0;
      j_q            <= '0;
      i_q            <= '0;
      b_q            <= '0;
      found_q        <= 1'b0;
      opening_q      <= 1'b0;
      best_q         <= '0;
      best_left_q    <= '0;
      result_valid_o <= 1'b0;
      result_o       <= '0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= 1'b0;
      case (state_q)
        IDLE: if (accept) begin
          case (item_i.op)
            fdbp_pkg::OpVehicle: begin
              if (vcount_q < BcW'(MAX_BINS)) vcount_q <= vcount_q + BcW'(1);
              else overflow_q <= 1'b1;
            end
            fdbp_pkg::OpClear: vcount_q <= '0;
            fdbp_pkg::OpRequest: begin
              last_q <= item_i.last;
              j_q    <= rcount_q;
              i_q    <= '0;
              if (rcount_q >= RcW'(MAX_REQUESTS)) overflow_q <= 1'b1;
            end
            default: ;
          endcase
        end
        INS_RD: if (j_q == '0) rcount_q <= rcount_q + RcW'(1);
        INS_CMP: begin
          if (rdata_q.size < new_q.size) j_q <= jm1;
          else rcount_q <= rcount_q + RcW'(1);
        end
        PK_RD: begin
          b_q       <= '0;
          found_q   <= 1'b0;
          opening_q <= 1'b0;
        end
        PK_SCAN: begin
          if (b_q < open_q) begin
            if (better) begin
              found_q     <= 1'b1;
              best_q      <= b_q[BiW-1:0];
              best_left_q <= fit.left;
            end
            b_q <= b_q + BcW'(1);
          end else if (!found_q && open_q < vcount_q && open_q < BcW'(MAX_BINS)) begin
            found_q   <= 1'b1;
            opening_q <= 1'b1;
            best_q    <= open_q[BiW-1:0];
            open_q    <= open_q + BcW'(1);
          end
        end
        PK_PLACE: begin
          result_valid_o          <= 1'b1;
          result_o.kind           <= 1'b0;
          result_o.out_request_id <= rdata_q.id;
          result_o.bin_index      <= found_q ? fdbp_pkg::BinW'(best_q) : '0;
          result_o.assigned       <= found_q;
          result_o.bin_load       <= '0;
          result_o.bin_cost       <= '0;
          result_o.overflow       <= overflow_q;
          result_o.last_out       <= (i_q + RcW'(1) == rcount_q) && (open_q == '0);
          i_q <= i_q + RcW'(1);
          b_q <= '0;
          if (i_q + RcW'(1) == rcount_q && open_q == '0) begin
            rcount_q   <= '0;
            overflow_q <= 1'b0;
          end
        end
        BIN_EMIT: begin
          result_valid_o          <= 1'b1;
          result_o.kind           <= 1'b1;
          result_o.out_request_id <= '0;
          result_o.bin_index      <= fdbp_pkg::BinW'(b_q[BiW-1:0]);
          result_o.assigned       <= 1'b0;
          result_o.bin_load       <= load_q[rd_idx];
          result_o.bin_cost       <= cost_q[rd_idx];
          result_o.overflow       <= overflow_q;
          result_o.last_out       <= b_q + BcW'(1) == open_q;
          b_q <= b_q + BcW'(1);
          if (b_q + BcW'(1) == open_q) begin
            rcount_q   <= '0;
            open_q     <= '0;
            overflow_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == PK_PLACE || $past(state_q) == BIN_EMIT))
    else $error("result strobe outside an emitting step");
  a_idle_no_bins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == IDLE |-> open_q == '0)
    else $error("bins left open while idle");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcount_q <= RcW'(MAX_REQUESTS) && vcount_q <= BcW'(MAX_BINS))
    else $error("request or vehicle count beyond capacity");
  a_place_open_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PK_PLACE && found_q) |-> BcW'(best_q) < open_q)
    else $error("item placed in a bin that is not open");

endmodule
`default_nettype wire

FILE: rtl/fdbp_fit_unit.sv
// Shared bin arithmetic: fit test, leftover space and saturating load and cost sums.
`default_nettype none
module fdbp_fit_unit (
  input  wire logic [15:0]                load_i,
  input  wire logic [14:0]                size_i,
  input  wire logic [15:0]                cap_i,
  input  wire logic [fdbp_pkg::CostW-1:0] cost_i,
  input  wire logic [15:0]                dist_i,
  output fdbp_pkg::fit_res_t              res_o
);
  logic [16:0] sum;
  logic [fdbp_pkg::CostW:0] csum;

  always_comb begin
    sum  = {1'b0, load_i} + {2'b00, size_i};
    csum = {1'b0, cost_i} + (fdbp_pkg::CostW + 1)'(dist_i);
    res_o.fits     = sum <= {1'b0, cap_i};
    res_o.left     = cap_i - sum[15:0];
    res_o.new_load = sum[16] ? 16'hFFFF : sum[15:0];
    res_o.new_cost = csum[fdbp_pkg::CostW] ? {fdbp_pkg::CostW{1'b1}}
                                           : csum[fdbp_pkg::CostW-1:0];
  end
endmodule
`default_nettype wire
